// ===== hdl/wfrc_pkg.sv =====
// shared types and constants for the wildcard flow rule classifier
package wfrc_pkg;

   localparam logic [1:0] CMD_CHECK    = 2'd0;
   localparam logic [1:0] CMD_REGISTER = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;
   localparam logic [1:0] CMD_SPARE    = 2'd3;

   localparam logic [2:0] ST_ALLOW   = 3'd0;
   localparam logic [2:0] ST_NO_RULE = 3'd1;
   localparam logic [2:0] ST_DENY    = 3'd2;
   localparam logic [2:0] ST_BAD     = 3'd3;
   localparam logic [2:0] ST_WRITTEN = 3'd4;
   localparam logic [2:0] ST_AUTH    = 3'd5;
   localparam logic [2:0] ST_FULL    = 3'd6;
   localparam logic [2:0] ST_CLEARED = 3'd7;

   localparam logic [10:0] SCORE_APP   = 11'd1000;
   localparam logic [10:0] SCORE_PROTO = 11'd100;
   localparam logic [10:0] SCORE_PORT  = 11'd40;
   localparam logic [10:0] SCORE_RTAG  = 11'd20;

   localparam logic [0:0] REG_GUARD = 1'd0;
   localparam logic [0:0] REG_LEVEL = 1'd1;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] app_tag;
      logic [7:0]  protocol;
      logic [15:0] peer_port;
      logic [31:0] peer_tag;
      logic        effect;
      logic [1:0]  writer_level;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  status;
      logic        rule_found;
      logic [5:0]  rule_index;
      logic        match_effect;
      logic [31:0] policy_epoch_out;
      logic [31:0] total_out;
      logic [31:0] allowed_out;
      logic [31:0] denied_out;
      logic [31:0] updates_out;
      logic [31:0] auth_rejects_out;
   } rsp_type;

endpackage

// ===== hdl/wildcard_flow_rule_classifier_core.sv =====
// top level of the wildcard flow rule classifier
// commands enter on req_start/req_data and are taken while req_busy is low.
// a short queue holds accepted commands; the engine behind it takes one at a
// time. a check or register walks the valid rules one per cycle through the
// rule memory read port; a register that finds an identical rule stops the
// walk there. a clear, a bad check, an auth reject or an unused command
// does not walk the table. the engine pops each command from the queue in the
// cycle before its result shows. each result is shown on rsp_data for one
// cycle with rsp_valid high, in command order; the receiver cannot stall, so
// no result waits.
// req_busy is high while the queue is full.
// csr port: address 0 write_guard_enable, address 4 min_write_level.
// synchronous reset empties the table (rule fill 0), zeroes the counters
// and loads the guard defaults; the rule memory itself is not cleared.
module wildcard_flow_rule_classifier_core #(
   parameter int RULE_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              req_busy,
   input  wfrc_pkg::req_type req_data,
   output logic              rsp_valid,
   output wfrc_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic guard_ff, guard_in;
   logic [1:0] level_ff, level_in;
   logic q_ne, q_full, q_pop, wr;
   wfrc_pkg::req_type q_head;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0;

   always_comb begin
      guard_in = guard_ff;
      level_in = level_ff;
      if (wr && csr_paddr[2] == wfrc_pkg::REG_GUARD) guard_in = csr_pwdata[0];
      if (wr && csr_paddr[2] == wfrc_pkg::REG_LEVEL) level_in = csr_pwdata[1:0];
      if (csr_paddr[1:0] != 2'd0) csr_prdata = 32'd0;
      else if (csr_paddr[2] == wfrc_pkg::REG_GUARD) csr_prdata = {31'd0, guard_ff};
      else csr_prdata = {30'd0, level_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff <= 1'b1;
         level_ff <= 2'd2;
      end else begin
         guard_ff <= guard_in;
         level_ff <= level_in;
      end
   end

   assign req_busy = q_full;

   wfrc_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_start && !q_full), .push_data(req_data),
      .pop(q_pop), .not_empty(q_ne), .full(q_full), .head(q_head)
   );

   wfrc_engine #(.RULE_ENTRIES(RULE_ENTRIES)) u_engine (
      .clock(clock), .reset(reset),
      .item_valid(q_ne), .item(q_head), .item_pop(q_pop),
      .guard_enable(guard_ff), .write_floor(level_ff),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );
endmodule

// ===== hdl/wfrc_queue.sv =====
// two-entry queue between the front and back parts
module wfrc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wfrc_pkg::req_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output wfrc_pkg::req_type head
);
   wfrc_pkg::req_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign head      = mem_ff[rd_ptr_ff];
endmodule

// ===== hdl/wfrc_engine.sv =====
// back part: walks the rule table one entry a cycle for a check or register and builds the result
module wfrc_engine #(
   parameter int RULE_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  wfrc_pkg::req_type item,
   output logic              item_pop,
   input  logic              guard_enable,
   input  logic [1:0]        write_floor,
   output logic              rsp_valid,
   output wfrc_pkg::rsp_type rsp_data
);
   localparam int IW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam int CW = $clog2(RULE_ENTRIES + 1);
   localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_DONE = 2'd2;

   logic [31:0] app_mem [RULE_ENTRIES];
   logic [7:0]  proto_mem [RULE_ENTRIES];
   logic [15:0] port_mem [RULE_ENTRIES];
   logic [31:0] rtag_mem [RULE_ENTRIES];
   logic        eff_mem [RULE_ENTRIES];

   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] scan_ff, scan_in, count_ff, count_in;
   logic [31:0] rd_app_ff, rd_rtag_ff;
   logic [7:0]  rd_proto_ff;
   logic [15:0] rd_port_ff;
   logic        rd_eff_ff, rd_valid_ff, rd_valid_in;
   logic [IW-1:0] rd_idx_ff;
   logic        have_ff, have_in, top_deny_ff, top_deny_in, hit_ff, hit_in;
   logic [10:0] top_score_ff, top_score_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [31:0] epoch_ff, epoch_in, total_ff, total_in, allowed_ff, allowed_in;
   logic [31:0] denied_ff, denied_in, upd_ff, upd_in, rej_ff, rej_in;
   logic        rsp_valid_ff, rsp_valid_in;
   wfrc_pkg::rsp_type rsp_ff, rsp_in;
   logic        wr_en;
   logic [IW-1:0] wr_idx;
   logic        wr_full;

   logic [10:0] score;
   logic        miss, same, is_check, bad, auth_fail;
   logic [IW-1:0] scan_idx;

   assign scan_idx = scan_ff[IW-1:0];
   assign is_check = item.command == wfrc_pkg::CMD_CHECK;
   assign bad = item.app_tag == 32'd0 || item.protocol == 8'd0 || item.peer_port == 16'd0;
   assign auth_fail = guard_enable && item.writer_level < write_floor;

   // per-entry score and identity test on the registered read
   always_comb begin
      score = 11'd0;
      miss = 1'b0;
      if (rd_app_ff != 32'd0) begin
         if (rd_app_ff != item.app_tag) miss = 1'b1;
         score = score + wfrc_pkg::SCORE_APP;
      end
      if (rd_proto_ff != 8'd0) begin
         if (rd_proto_ff != item.protocol) miss = 1'b1;
         score = score + wfrc_pkg::SCORE_PROTO;
      end
      if (rd_port_ff != 16'd0) begin
         if (rd_port_ff != item.peer_port) miss = 1'b1;
         score = score + wfrc_pkg::SCORE_PORT;
      end
      if (rd_rtag_ff != 32'd0) begin
         if (rd_rtag_ff != item.peer_tag) miss = 1'b1;
         score = score + wfrc_pkg::SCORE_RTAG;
      end
      if (miss) score = 11'd0;
      same = rd_app_ff == item.app_tag && rd_proto_ff == item.protocol &&
             rd_port_ff == item.peer_port && rd_rtag_ff == item.peer_tag;
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      rd_valid_in   = 1'b0;
      have_in       = have_ff;
      top_deny_in   = top_deny_ff;
      top_score_in  = top_score_ff;
      best_idx_in   = best_idx_ff;
      hit_in        = hit_ff;
      epoch_in      = epoch_ff;
      total_in      = total_ff;
      allowed_in    = allowed_ff;
      denied_in     = denied_ff;
      upd_in        = upd_ff;
      rej_in        = rej_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      item_pop      = 1'b0;
      wr_en         = 1'b0;
      wr_idx        = count_ff[IW-1:0];
      wr_full       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               scan_in      = '0;
               have_in      = 1'b0;
               hit_in       = 1'b0;
               top_score_in = 11'd0;
               top_deny_in  = 1'b0;
               best_idx_in  = '0;
               if (item.command == wfrc_pkg::CMD_CHECK ||
                   item.command == wfrc_pkg::CMD_REGISTER) begin
                  if ((is_check && bad) || (!is_check && auth_fail)) state_in = S_DONE;
                  else state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // issue a read for scan_ff, evaluate the read issued last cycle
            if (rd_valid_ff && !hit_ff) begin
               if (is_check) begin
                  if (score != 11'd0 && (!have_ff || score > top_score_ff ||
                      (score == top_score_ff && rd_eff_ff && !top_deny_ff))) begin
                     have_in = 1'b1;
                     top_score_in = score;
                     top_deny_in = rd_eff_ff;
                     best_idx_in = rd_idx_ff;
                  end
               end else if (same) begin
                  hit_in = 1'b1;
                  best_idx_in = rd_idx_ff;
               end
            end
            if (scan_ff < count_ff && !(hit_in)) begin
               rd_valid_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end else if (!rd_valid_ff || hit_in) begin
               state_in = S_DONE;
            end
         end
         default: begin
            item_pop = 1'b1;
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.accepted = 1'b0;
            rsp_in.status = wfrc_pkg::ST_BAD;
            rsp_in.rule_found = 1'b0;
            rsp_in.rule_index = 6'd0;
            rsp_in.match_effect = 1'b1;
            case (item.command)
               wfrc_pkg::CMD_CHECK: begin
                  total_in = total_ff + 32'd1;
                  if (bad) begin
                     denied_in = denied_ff + 32'd1;
                  end else if (!have_ff) begin
                     rsp_in.status = wfrc_pkg::ST_NO_RULE;
                     denied_in = denied_ff + 32'd1;
                  end else begin
                     rsp_in.rule_found = 1'b1;
                     rsp_in.rule_index = 6'(best_idx_ff);
                     rsp_in.match_effect = top_deny_ff;
                     if (top_deny_ff) begin
                        rsp_in.status = wfrc_pkg::ST_DENY;
                        denied_in = denied_ff + 32'd1;
                     end else begin
                        rsp_in.accepted = 1'b1;
                        rsp_in.status = wfrc_pkg::ST_ALLOW;
                        allowed_in = allowed_ff + 32'd1;
                     end
                  end
               end
               wfrc_pkg::CMD_REGISTER: begin
                  if (auth_fail) begin
                     rej_in = rej_ff + 32'd1;
                     rsp_in.status = wfrc_pkg::ST_AUTH;
                  end else if (hit_ff || count_ff < CW'(RULE_ENTRIES)) begin
                     wr_en = 1'b1;
                     wr_full = !hit_ff;
                     if (hit_ff) wr_idx = best_idx_ff;
                     else count_in = count_ff + 1'b1;
                     upd_in = upd_ff + 32'd1;
                     epoch_in = epoch_ff + 32'd1;
                     rsp_in.accepted = 1'b1;
                     rsp_in.status = wfrc_pkg::ST_WRITTEN;
                     rsp_in.rule_found = 1'b1;
                     rsp_in.rule_index = 6'(wr_idx);
                     rsp_in.match_effect = item.effect;
                  end else begin
                     rsp_in.status = wfrc_pkg::ST_FULL;
                  end
               end
               wfrc_pkg::CMD_CLEAR: begin
                  count_in = '0;
                  epoch_in = epoch_ff + 32'd1;
                  upd_in = upd_ff + 32'd1;
                  rsp_in.accepted = 1'b1;
                  rsp_in.status = wfrc_pkg::ST_CLEARED;
               end
               default: ;
            endcase
            rsp_in.policy_epoch_out = epoch_in;
            rsp_in.total_out = total_in;
            rsp_in.allowed_out = allowed_in;
            rsp_in.denied_out = denied_in;
            rsp_in.updates_out = upd_in;
            rsp_in.auth_rejects_out = rej_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff <= '0;
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
         have_ff <= 1'b0;
         hit_ff <= 1'b0;
         top_deny_ff <= 1'b0;
         top_score_ff <= 11'd0;
         best_idx_ff <= '0;
         epoch_ff <= 32'd0;
         total_ff <= 32'd0;
         allowed_ff <= 32'd0;
         denied_ff <= 32'd0;
         upd_ff <= 32'd0;
         rej_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff <= scan_in;
         count_ff <= count_in;
         rd_valid_ff <= rd_valid_in;
         have_ff <= have_in;
         hit_ff <= hit_in;
         top_deny_ff <= top_deny_in;
         top_score_ff <= top_score_in;
         best_idx_ff <= best_idx_in;
         epoch_ff <= epoch_in;
         total_ff <= total_in;
         allowed_ff <= allowed_in;
         denied_ff <= denied_in;
         upd_ff <= upd_in;
         rej_ff <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      rd_idx_ff <= scan_idx;
      rd_app_ff <= app_mem[scan_idx];
      rd_proto_ff <= proto_mem[scan_idx];
      rd_port_ff <= port_mem[scan_idx];
      rd_rtag_ff <= rtag_mem[scan_idx];
      rd_eff_ff <= eff_mem[scan_idx];
      if (wr_en) begin
         eff_mem[wr_idx] <= item.effect;
         if (wr_full) begin
            app_mem[wr_idx] <= item.app_tag;
            proto_mem[wr_idx] <= item.protocol;
            port_mem[wr_idx] <= item.peer_port;
            rtag_mem[wr_idx] <= item.peer_tag;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== bench/tb.sv =====
// self-checking regression bench for the wildcard flow rule classifier core
`timescale 1ns / 1ps

module tb;

   localparam int ENTRIES = 64;
   localparam int CYCLE_LIMIT = 2000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_start = 1'b0;
   logic              req_busy;
   wfrc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   wfrc_pkg::rsp_type rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   wildcard_flow_rule_classifier_core dut (.*);

   always #10 clock = ~clock;

   // shadow of the classifier state
   logic [31:0] tbl_app [ENTRIES];
   logic [7:0]  tbl_proto [ENTRIES];
   logic [15:0] tbl_port [ENTRIES];
   logic [31:0] tbl_rtag [ENTRIES];
   logic        tbl_eff [ENTRIES];
   int          tbl_count;
   logic [31:0] cnt_epoch, cnt_total, cnt_allow, cnt_deny, cnt_upd, cnt_rej;
   logic        guard_on;
   logic [1:0]  guard_level;

   wfrc_pkg::rsp_type pending_rsp[$];
   int          errors = 0;
   int          cycles = 0;
   bit          gaps_on = 1'b1;

   // a small pool of keys, so random checks and rewrites hit real rules
   logic [31:0] pool_app [8];
   logic [7:0]  pool_proto [8];
   logic [15:0] pool_port [8];
   logic [31:0] pool_rtag [8];

   function automatic int rule_score(int i, wfrc_pkg::req_type r);
      int s;
      s = 0;
      if (tbl_app[i] != 0) begin
         if (tbl_app[i] != r.app_tag) return 0;
         s += 1000;
      end
      if (tbl_proto[i] != 0) begin
         if (tbl_proto[i] != r.protocol) return 0;
         s += 100;
      end
      if (tbl_port[i] != 0) begin
         if (tbl_port[i] != r.peer_port) return 0;
         s += 40;
      end
      if (tbl_rtag[i] != 0) begin
         if (tbl_rtag[i] != r.peer_tag) return 0;
         s += 20;
      end
      return s;
   endfunction

   function automatic wfrc_pkg::rsp_type classify(wfrc_pkg::req_type r);
      wfrc_pkg::rsp_type o;
      bit have, done;
      int best, top_score, s;
      logic top_deny;
      o = '0;
      o.status = wfrc_pkg::ST_BAD;
      o.match_effect = 1'b1;
      if (r.command == wfrc_pkg::CMD_CHECK) begin
         cnt_total++;
         if (r.app_tag == 0 || r.protocol == 0 || r.peer_port == 0) begin
            cnt_deny++;
         end else begin
            have = 0; best = 0; top_score = 0; top_deny = 0;
            for (int i = 0; i < tbl_count; i++) begin
               s = rule_score(i, r);
               if (s != 0 && (!have || s > top_score ||
                              (s == top_score && tbl_eff[i] && !top_deny))) begin
                  have = 1; best = i; top_score = s; top_deny = tbl_eff[i];
               end
            end
            if (!have) begin
               o.status = wfrc_pkg::ST_NO_RULE;
               cnt_deny++;
            end else begin
               o.rule_found = 1'b1;
               o.rule_index = best[5:0];
               o.match_effect = top_deny;
               if (!top_deny) begin
                  o.accepted = 1'b1;
                  o.status = wfrc_pkg::ST_ALLOW;
                  cnt_allow++;
               end else begin
                  o.status = wfrc_pkg::ST_DENY;
                  cnt_deny++;
               end
            end
         end
      end else if (r.command == wfrc_pkg::CMD_REGISTER) begin
         if (guard_on && r.writer_level < guard_level) begin
            cnt_rej++;
            o.status = wfrc_pkg::ST_AUTH;
         end else begin
            done = 0;
            for (int i = 0; i < tbl_count && !done; i++)
               if (tbl_app[i] == r.app_tag && tbl_proto[i] == r.protocol &&
                   tbl_port[i] == r.peer_port && tbl_rtag[i] == r.peer_tag) begin
                  tbl_eff[i] = r.effect;
                  done = 1;
                  o.rule_index = i[5:0];
               end
            if (!done && tbl_count < ENTRIES) begin
               o.rule_index = tbl_count[5:0];
               tbl_app[tbl_count] = r.app_tag;
               tbl_proto[tbl_count] = r.protocol;
               tbl_port[tbl_count] = r.peer_port;
               tbl_rtag[tbl_count] = r.peer_tag;
               tbl_eff[tbl_count] = r.effect;
               tbl_count++;
               done = 1;
            end
            if (done) begin
               cnt_upd++;
               cnt_epoch++;
               o.accepted = 1'b1;
               o.status = wfrc_pkg::ST_WRITTEN;
               o.rule_found = 1'b1;
               o.match_effect = r.effect;
            end else begin
               o.status = wfrc_pkg::ST_FULL;
            end
         end
      end else if (r.command == wfrc_pkg::CMD_CLEAR) begin
         tbl_count = 0;
         cnt_epoch++;
         cnt_upd++;
         o.accepted = 1'b1;
         o.status = wfrc_pkg::ST_CLEARED;
      end
      o.policy_epoch_out = cnt_epoch;
      o.total_out = cnt_total;
      o.allowed_out = cnt_allow;
      o.denied_out = cnt_deny;
      o.updates_out = cnt_upd;
      o.auth_rejects_out = cnt_rej;
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("wildcard_flow_rule_classifier_core regression: fail");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      wfrc_pkg::rsp_type w;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected result", 32'(rsp_data.status), 32'd0);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_data.accepted !== w.accepted)
               report("accepted", 32'(rsp_data.accepted), 32'(w.accepted));
            if (rsp_data.status !== w.status)
               report("status", 32'(rsp_data.status), 32'(w.status));
            if (rsp_data.rule_found !== w.rule_found)
               report("rule_found", 32'(rsp_data.rule_found), 32'(w.rule_found));
            if (rsp_data.rule_index !== w.rule_index)
               report("rule_index", 32'(rsp_data.rule_index), 32'(w.rule_index));
            if (rsp_data.match_effect !== w.match_effect)
               report("match_effect", 32'(rsp_data.match_effect), 32'(w.match_effect));
            if (rsp_data.policy_epoch_out !== w.policy_epoch_out)
               report("epoch", rsp_data.policy_epoch_out, w.policy_epoch_out);
            if (rsp_data.total_out !== w.total_out)
               report("total", rsp_data.total_out, w.total_out);
            if (rsp_data.allowed_out !== w.allowed_out)
               report("allowed", rsp_data.allowed_out, w.allowed_out);
            if (rsp_data.denied_out !== w.denied_out)
               report("denied", rsp_data.denied_out, w.denied_out);
            if (rsp_data.updates_out !== w.updates_out)
               report("updates", rsp_data.updates_out, w.updates_out);
            if (rsp_data.auth_rejects_out !== w.auth_rejects_out)
               report("auth_rejects", rsp_data.auth_rejects_out, w.auth_rejects_out);
         end
      end
   end

   task automatic send_command(wfrc_pkg::req_type r);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      // transfer taken at this edge
      pending_rsp.push_back(classify(r));
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_start <= 1'b0;
      while (pending_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (ENTRIES + 10) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == 3'd4 * wfrc_pkg::REG_GUARD) guard_on = value[0];
      else guard_level = value[1:0];
      @(posedge clock);
   endtask

   task automatic set_guard(logic on, logic [1:0] level);
      drain();
      csr_write(3'd4 * wfrc_pkg::REG_GUARD, {31'd0, on});
      csr_write(3'd4 * wfrc_pkg::REG_LEVEL, {30'd0, level});
   endtask

   function automatic wfrc_pkg::req_type make_cmd(logic [1:0] c, logic [31:0] a,
                                                   logic [7:0] p, logic [15:0] pt,
                                                   logic [31:0] t, logic e,
                                                   logic [1:0] lv);
      wfrc_pkg::req_type r;
      r.command = c; r.app_tag = a; r.protocol = p; r.peer_port = pt;
      r.peer_tag = t; r.effect = e; r.writer_level = lv;
      return r;
   endfunction

   task automatic test_directed;
      // auth reject under reset guard, then privileged writes
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd5, 8'd6, 16'd80, 32'd0, 1'b0, 2'd1));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd5, 8'd6, 16'd80, 32'd9, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd5, 8'd6, 16'd80, 32'd0, 1'b0, 2'd2));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd0, 8'd6, 16'd0, 32'd0, 1'b1, 2'd3));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0, 2'd3));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, '1, '1, '1, '1, 1'b1, 2'd3));
      // allow wins, then deny after the matching rule is rewritten to deny
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd5, 8'd6, 16'd80, 32'd9, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd5, 8'd6, 16'd0, 32'd0, 1'b1, 2'd3));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd5, 8'd6, 16'd80, 32'd0, 1'b1, 2'd3));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd5, 8'd6, 16'd80, 32'd9, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd7, 8'd6, 16'd81, 32'd9, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, '1, '1, '1, '1, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd1, 8'd9, 16'd9, 32'd0, 1'b0, 2'd0));
      // bad input on each checked key: app tag, protocol, peer port
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd0, 8'd6, 16'd80, 32'd9, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd5, 8'd0, 16'd80, 32'd9, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd5, 8'd6, 16'd0, 32'd9, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_SPARE, '1, '1, '1, '1, 1'b1, 2'd3));
      send_command(make_cmd(wfrc_pkg::CMD_CLEAR, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0, 2'd0));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'd5, 8'd6, 16'd80, 32'd9, 1'b0, 2'd0));
   endtask

   task automatic test_guard_settings;
      set_guard(1'b0, 2'd3);
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd11, 8'd1, 16'd1, 32'd1, 1'b0, 2'd0));
      set_guard(1'b1, 2'd3);
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd12, 8'd1, 16'd1, 32'd1, 1'b0, 2'd2));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd12, 8'd1, 16'd1, 32'd1, 1'b0, 2'd3));
      set_guard(1'b1, 2'd0);
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'd13, 8'd1, 16'd1, 32'd1, 1'b1, 2'd0));
   endtask

   task automatic test_table_full;
      // fill to capacity, hit full, then rewrite an existing rule
      for (int i = 0; i < ENTRIES + 2; i++)
         send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'h100 + i, 8'd3, 16'd0, 32'd0,
                               i[0], 2'd3));
      send_command(make_cmd(wfrc_pkg::CMD_REGISTER, 32'h100, 8'd3, 16'd0, 32'd0, 1'b1, 2'd3));
      send_command(make_cmd(wfrc_pkg::CMD_CHECK, 32'h100 + ENTRIES - 1, 8'd3, 16'd4, 32'd4,
                            1'b0, 2'd0));
      drain();
      send_command(make_cmd(wfrc_pkg::CMD_CLEAR, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0, 2'd0));
   endtask

   function automatic wfrc_pkg::req_type random_cmd();
      wfrc_pkg::req_type r;
      int k, pick;
      r.app_tag = {$urandom()};
      r.protocol = 8'($urandom_range(0, 255));
      r.peer_port = 16'($urandom_range(0, 65535));
      r.peer_tag = {$urandom()};
      r.effect = 1'($urandom_range(0, 1));
      r.writer_level = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      if (pick < 45) r.command = wfrc_pkg::CMD_CHECK;
      else if (pick < 93) r.command = wfrc_pkg::CMD_REGISTER;
      else if (pick < 97) r.command = wfrc_pkg::CMD_CLEAR;
      else r.command = wfrc_pkg::CMD_SPARE;
      // draw keys from a small pool so rules overlap and checks match
      if ($urandom_range(0, 3) != 0) begin
         r.app_tag = pool_app[k];
         r.protocol = pool_proto[k];
         r.peer_port = pool_port[k];
         r.peer_tag = pool_rtag[k];
      end
      if (r.command == wfrc_pkg::CMD_REGISTER) begin
         if ($urandom_range(0, 2) == 0) r.app_tag = '0;
         if ($urandom_range(0, 2) == 0) r.protocol = '0;
         if ($urandom_range(0, 2) == 0) r.peer_port = '0;
         if ($urandom_range(0, 2) == 0) r.peer_tag = '0;
      end else if (r.command == wfrc_pkg::CMD_CHECK && $urandom_range(0, 15) == 0) begin
         r.protocol = '0;
      end
      return r;
   endfunction

   task automatic test_random(int count);
      for (int i = 0; i < 8; i++) begin
         pool_app[i] = (i < 2) ? {$urandom()} : $urandom_range(1, 4);
         pool_proto[i] = (i == 7) ? 8'hff : 8'($urandom_range(1, 3));
         pool_port[i] = (i == 6) ? 16'hffff : 16'($urandom_range(1, 3));
         pool_rtag[i] = (i == 5) ? 32'hffffffff : $urandom_range(0, 2);
      end
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            drain();
            set_guard(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
         end
         send_command(random_cmd());
      end
   endtask

   initial begin
      tbl_count = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_app[i] = 0; tbl_proto[i] = 0; tbl_port[i] = 0; tbl_rtag[i] = 0;
         tbl_eff[i] = 0;
      end
      {cnt_epoch, cnt_total, cnt_allow, cnt_deny, cnt_upd, cnt_rej} = '0;
      guard_on = 1'b1;
      guard_level = 2'd2;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_guard_settings();
      test_table_full();
      set_guard(1'b1, 2'd1);
      test_random(400);
      set_guard(1'b0, 2'd2);
      gaps_on = 1'b0;
      test_random(400);

      drain();
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("wildcard_flow_rule_classifier_core regression: pass");
      end else begin
         $display("wildcard_flow_rule_classifier_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/wfrc_pkg.sv
hdl/wfrc_queue.sv
hdl/wfrc_engine.sv
hdl/wildcard_flow_rule_classifier_core.sv
bench/tb.sv
